// File: hw/rtl/blk3_pkg.sv
// Shared constants and types for the BLAKE3 stream hasher.
`default_nettype none
package blk3_pkg;

  typedef logic [31:0] word_t;

  localparam word_t IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [3:0] PERM [16] = '{
    4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
    4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
  };

  localparam logic [4:0] FL_CHUNK_START = 5'd1;
  localparam logic [4:0] FL_CHUNK_END   = 5'd2;
  localparam logic [4:0] FL_PARENT      = 5'd4;
  localparam logic [4:0] FL_ROOT        = 5'd8;
  localparam logic [4:0] FL_KEYED       = 5'd16;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BUF_WORDS   = 16;
  localparam int unsigned LAST_BLOCK  = 15;
  localparam int unsigned ROUNDS      = 7;

  typedef enum logic [2:0] {
    CFG_KEYED_MODE = 3'd0,
    CFG_KEY_0_7    = 3'd1,
    CFG_KEY_8_15   = 3'd2,
    CFG_KEY_16_23  = 3'd3,
    CFG_KEY_24_31  = 3'd4
  } cfg_idx_e;

endpackage
`default_nettype wire

// File: hw/rtl/blk3_in_if.sv
// Message byte channel.
`default_nettype none
interface blk3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/blk3_out_if.sv
// Digest word channel.
`default_nettype none
interface blk3_out_if;
  logic           valid;
  logic           ready;
  blk3_pkg::word_t digest_word;
  logic [2:0]     word_index;
  logic           last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/blake3_stream_hasher_top.sv
// BLAKE3-256 stream hasher: byte input, eight-word digest output.
//
//  channel   | dir | payload                                  | transfer
//  in_i      | in  | data_byte, byte_valid, end_of_message    | valid & ready
//  out_o     | out | digest_word, word_index, last_word       | valid & ready
//  cfg       | in  | cfg_idx_i, cfg_wdata_i                   | cfg_we_i
//
//  Flow: a byte that arrives on a block that is not full is written to the
//  buffer. A byte that arrives on a full block first has the buffer read,
//  then the rounds run (7 rounds of 8 G, one half-G per cycle) and unload,
//  and at a chunk end any parent merges run before the push.
//  End of message adds one compression per stack entry plus the root, then
//  8 output transfers. Throughput is set by the single shared G unit.
//  Reset clears all control state; buffer and stack memories are not cleared.
//  A stalled output holds the block in the output state; no input is taken.
`default_nettype none
module blake3_stream_hasher_top #(
  parameter int unsigned STACK_ENTRIES = 54
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  blk3_in_if.sink     in_i,
  blk3_out_if.source  out_o,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [63:0] cfg_wdata_i
);

  localparam int unsigned CW = $clog2(STACK_ENTRIES + 1);
  localparam int unsigned SW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PUT, S_LOAD, S_RUN, S_DONE, S_MRG, S_PAR, S_FIN_DEC, S_OUT
  } state_e;

  typedef enum logic [1:0] {PH_BLOCK, PH_MERGE, PH_FIN, PH_ROOT} phase_e;

  state_e state_q;
  phase_e phase_q;

  // configuration
  logic        keyed_q;
  logic [63:0] key_q [4];

  // message state
  logic [6:0]    fill_q;
  logic [3:0]    bdone_q;
  logic [63:0]   cctr_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] fin_i_q;
  logic [63:0]   total_q;
  blk3_pkg::word_t chain_q [8];
  blk3_pkg::word_t nv_q [8];

  // latched input item
  logic [7:0] ibyte_q;
  logic       ibv_q;
  logic       ieom_q;

  // compression engine
  blk3_pkg::word_t v_q [16];
  blk3_pkg::word_t m_q [16];
  logic [2:0] rnd_q;
  logic [2:0] g_q;
  logic       half_q;
  logic [4:0] wcnt_q;

  // output
  blk3_pkg::word_t dig_q [8];
  logic [2:0] oidx_q;

  // block buffer memory: 16 words, byte writes
  blk3_pkg::word_t buf_mem [blk3_pkg::BUF_WORDS];
  blk3_pkg::word_t buf_rd_q;
  logic            buf_we;
  logic            buf_re;

  // stack memory: one 256-bit chaining value per entry
  logic [255:0] stk_mem [STACK_ENTRIES];
  logic [255:0] stk_rd_q;
  logic         stk_we;
  logic         stk_re;
  logic [SW-1:0] stk_waddr;
  logic [SW-1:0] stk_raddr;
  logic [CW-1:0] push_idx;
  logic [255:0] nv_flat;

  blk3_pkg::word_t base [8];
  logic [4:0] mode_flag;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      base[i] = keyed_q ? key_q[i/2][32*(i%2) +: 32] : blk3_pkg::IV[i];
    end
    mode_flag = keyed_q ? blk3_pkg::FL_KEYED : 5'd0;
    for (int i = 0; i < 8; i++) nv_flat[32*i +: 32] = nv_q[i];
  end

  // ---- G unit (one half of G per cycle) ----
  logic [1:0] gk;
  logic [3:0] ia, ib, ic, id;
  blk3_pkg::word_t x, na, nd, nc, nb, td, tb;

  always_comb begin
    gk = g_q[1:0];
    ia = {2'b00, gk};
    ib = {2'b01, gk + (g_q[2] ? 2'd1 : 2'd0)};
    ic = {2'b10, gk + (g_q[2] ? 2'd2 : 2'd0)};
    id = {2'b11, gk + (g_q[2] ? 2'd3 : 2'd0)};
    x  = m_q[{g_q, half_q}];
    na = v_q[ia] + v_q[ib] + x;
    td = v_q[id] ^ na;
    nd = half_q ? {td[7:0], td[31:8]} : {td[15:0], td[31:16]};
    nc = v_q[ic] + nd;
    tb = v_q[ib] ^ nc;
    nb = half_q ? {tb[6:0], tb[31:7]} : {tb[11:0], tb[31:12]};
  end

  // ---- memory control ----
  logic done_last;
  assign done_last = (rnd_q == 3'(blk3_pkg::ROUNDS - 1)) && (g_q == 3'd7) && half_q;

  always_comb begin
    buf_we    = (state_q == S_PUT) && ibv_q;
    buf_re    = (state_q == S_LOAD) && !wcnt_q[4];
    push_idx  = (cnt_q >= CW'(STACK_ENTRIES)) ? CW'(STACK_ENTRIES - 1) : cnt_q;
    stk_waddr = push_idx[SW-1:0];
    stk_we    = (state_q == S_MRG) && !(!total_q[0] && (cnt_q != '0));
    stk_re    = 1'b0;
    stk_raddr = '0;
    if (state_q == S_MRG && !total_q[0] && (cnt_q != '0)) begin
      stk_re    = 1'b1;
      stk_raddr = SW'(cnt_q - CW'(1));
    end else if (state_q == S_DONE && phase_q == PH_FIN) begin
      stk_re    = 1'b1;
      stk_raddr = SW'(fin_i_q - CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[fill_q[5:2]][8*fill_q[1:0] +: 8] <= ibyte_q;
    if (buf_re) buf_rd_q <= buf_mem[wcnt_q[3:0]];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= nv_flat;
    if (stk_re) stk_rd_q <= stk_mem[stk_raddr];
  end

  // masked buffer word: bytes at and past the fill point read as zero
  blk3_pkg::word_t bword;
  logic [3:0] lw;
  always_comb begin
    lw = wcnt_q[3:0] - 4'd1;
    for (int j = 0; j < 4; j++) begin
      bword[8*j +: 8] = ({1'b0, lw, 2'(j)} < fill_q) ? buf_rd_q[8*j +: 8] : 8'd0;
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.digest_word = dig_q[oidx_q];
  assign out_o.word_index  = oidx_q;
  assign out_o.last_word   = (oidx_q == 3'd7);

  // ---- control and datapath registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_BLOCK;
      keyed_q <= 1'b0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      fill_q  <= '0;
      bdone_q <= '0;
      cctr_q  <= '0;
      cnt_q   <= '0;
      fin_i_q <= '0;
      rnd_q   <= '0;
      g_q     <= '0;
      half_q  <= 1'b0;
      wcnt_q  <= '0;
      oidx_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          blk3_pkg::CFG_KEYED_MODE: keyed_q  <= cfg_wdata_i[0];
          blk3_pkg::CFG_KEY_0_7:    key_q[0] <= cfg_wdata_i;
          blk3_pkg::CFG_KEY_8_15:   key_q[1] <= cfg_wdata_i;
          blk3_pkg::CFG_KEY_16_23:  key_q[2] <= cfg_wdata_i;
          blk3_pkg::CFG_KEY_24_31:  key_q[3] <= cfg_wdata_i;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            ibyte_q <= in_i.data_byte;
            ibv_q   <= in_i.byte_valid;
            ieom_q  <= in_i.end_of_message;
            wcnt_q  <= '0;
            if (in_i.byte_valid && fill_q == 7'(blk3_pkg::BLOCK_BYTES)) begin
              phase_q <= PH_BLOCK;
              state_q <= S_LOAD;
            end else begin
              state_q <= S_PUT;
            end
          end
        end

        S_PUT: begin
          if (ibv_q) fill_q <= fill_q + 7'd1;
          wcnt_q <= '0;
          if (ieom_q) begin
            phase_q <= PH_FIN;
            state_q <= S_LOAD;
          end else begin
            state_q <= S_IDLE;
          end
        end

        S_LOAD: begin
          if (wcnt_q != '0) m_q[lw] <= bword;
          wcnt_q <= wcnt_q + 5'd1;
          if (wcnt_q[4]) begin
            for (int i = 0; i < 8; i++) begin
              v_q[i] <= (bdone_q == '0) ? base[i] : chain_q[i];
            end
            for (int i = 0; i < 4; i++) v_q[8+i] <= blk3_pkg::IV[i];
            v_q[12] <= cctr_q[31:0];
            v_q[13] <= cctr_q[63:32];
            v_q[14] <= (phase_q == PH_BLOCK) ? 32'(blk3_pkg::BLOCK_BYTES) : 32'(fill_q);
            v_q[15] <= 32'(mode_flag
                         | ((bdone_q == '0) ? blk3_pkg::FL_CHUNK_START : 5'd0)
                         | (((phase_q == PH_FIN)
                             || (bdone_q == 4'(blk3_pkg::LAST_BLOCK)))
                            ? blk3_pkg::FL_CHUNK_END : 5'd0));
            rnd_q  <= '0;
            g_q    <= '0;
            half_q <= 1'b0;
            if (phase_q == PH_FIN) begin
              fin_i_q <= cnt_q;
              state_q <= S_FIN_DEC;
            end else begin
              state_q <= S_RUN;
            end
          end
        end

        S_RUN: begin
          v_q[ia] <= na;
          v_q[ib] <= nb;
          v_q[ic] <= nc;
          v_q[id] <= nd;
          half_q  <= !half_q;
          if (half_q) begin
            g_q <= g_q + 3'd1;
            if (g_q == 3'd7) begin
              rnd_q <= rnd_q + 3'd1;
              for (int i = 0; i < 16; i++) m_q[i] <= m_q[blk3_pkg::PERM[i]];
            end
          end
          if (done_last) state_q <= S_DONE;
        end

        S_DONE: begin
          unique case (phase_q)
            PH_BLOCK: begin
              if (bdone_q == 4'(blk3_pkg::LAST_BLOCK)) begin
                for (int i = 0; i < 8; i++) nv_q[i] <= v_q[i] ^ v_q[i+8];
                total_q <= cctr_q + 64'd1;
                state_q <= S_MRG;
              end else begin
                for (int i = 0; i < 8; i++) chain_q[i] <= v_q[i] ^ v_q[i+8];
                bdone_q <= bdone_q + 4'd1;
                fill_q  <= '0;
                state_q <= S_PUT;
              end
            end
            PH_MERGE: begin
              for (int i = 0; i < 8; i++) nv_q[i] <= v_q[i] ^ v_q[i+8];
              state_q <= S_MRG;
            end
            PH_FIN: begin
              for (int i = 0; i < 8; i++) nv_q[i] <= v_q[i] ^ v_q[i+8];
              fin_i_q <= fin_i_q - CW'(1);
              state_q <= S_PAR;
            end
            PH_ROOT: begin
              for (int i = 0; i < 8; i++) dig_q[i] <= v_q[i] ^ v_q[i+8];
              oidx_q  <= '0;
              fill_q  <= '0;
              bdone_q <= '0;
              cctr_q  <= '0;
              cnt_q   <= '0;
              state_q <= S_OUT;
            end
            default: ;
          endcase
        end

        S_MRG: begin
          if (!total_q[0] && (cnt_q != '0)) begin
            cnt_q   <= cnt_q - CW'(1);
            total_q <= {1'b0, total_q[63:1]};
            phase_q <= PH_MERGE;
            state_q <= S_PAR;
          end else begin
            // push the merged value; a full stack overwrites its top
            cnt_q   <= push_idx + CW'(1);
            cctr_q  <= cctr_q + 64'd1;
            bdone_q <= '0;
            fill_q  <= '0;
            state_q <= S_PUT;
          end
        end

        S_PAR: begin
          for (int i = 0; i < 8; i++) begin
            m_q[i]   <= stk_rd_q[32*i +: 32];
            m_q[8+i] <= nv_q[i];
            v_q[i]   <= base[i];
          end
          for (int i = 0; i < 4; i++) v_q[8+i] <= blk3_pkg::IV[i];
          v_q[12] <= '0;
          v_q[13] <= '0;
          v_q[14] <= 32'(blk3_pkg::BLOCK_BYTES);
          v_q[15] <= 32'(mode_flag | blk3_pkg::FL_PARENT);
          rnd_q   <= '0;
          g_q     <= '0;
          half_q  <= 1'b0;
          state_q <= (phase_q == PH_MERGE) ? S_RUN : S_FIN_DEC;
        end

        S_FIN_DEC: begin
          // last compression of the fold carries the root flag
          if (fin_i_q == '0) begin
            v_q[15] <= v_q[15] | 32'(blk3_pkg::FL_ROOT);
            v_q[12] <= '0;
            v_q[13] <= '0;
            phase_q <= PH_ROOT;
          end else begin
            phase_q <= PH_FIN;
          end
          state_q <= S_RUN;
        end

        S_OUT: begin
          if (out_o.ready) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: tb/blk3_digest_checker.sv
// Digest checker: tracks config writes and input transfers, predicts digests, compares output.
module blk3_digest_checker #(
  parameter int unsigned STACK_ENTRIES = 54
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [7:0]      data_byte_i,
  input  logic            byte_valid_i,
  input  logic            end_of_message_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  blk3_pkg::word_t digest_word_i,
  input  logic [2:0]      word_index_i,
  input  logic            last_word_i,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [63:0]     cfg_wdata_i,
  output int              err_count_o,
  output int              pending_o
);

  typedef logic [7:0][31:0]  cv_t;
  typedef logic [15:0][31:0] blk_t;

  typedef struct packed {
    blk3_pkg::word_t word;
    logic [2:0]      idx;
    logic            last;
  } digest_word_t;

  digest_word_t digest_q[$];

  logic        keyed_mode;
  logic [63:0] key_reg [4];
  cv_t         chain_cv;
  logic [7:0]  blk_buf [64];
  int unsigned fill;
  int unsigned blocks_done;
  logic [63:0] chunk_ctr;
  cv_t         val_stack [STACK_ENTRIES];
  int unsigned stack_depth;

  function automatic blk3_pkg::word_t rotr(blk3_pkg::word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic blk_t g_mix(blk_t s, int a, int b, int c, int d,
                                 blk3_pkg::word_t x, blk3_pkg::word_t y);
    s[a] = s[a] + s[b] + x;
    s[d] = rotr(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d];
    s[b] = rotr(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b] + y;
    s[d] = rotr(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d];
    s[b] = rotr(s[b] ^ s[c], 7);
    return s;
  endfunction

  function automatic cv_t compress(cv_t cv, blk_t msg, logic [63:0] ctr,
                                   blk3_pkg::word_t len, blk3_pkg::word_t flags);
    blk_t s;
    blk_t perm;
    cv_t  res;
    for (int i = 0; i < 8; i++) s[i] = cv[i];
    for (int i = 0; i < 4; i++) s[8 + i] = blk3_pkg::IV[i];
    s[12] = ctr[31:0];
    s[13] = ctr[63:32];
    s[14] = len;
    s[15] = flags;
    for (int r = 0; r < blk3_pkg::ROUNDS; r++) begin
      s = g_mix(s, 0, 4, 8, 12, msg[0], msg[1]);
      s = g_mix(s, 1, 5, 9, 13, msg[2], msg[3]);
      s = g_mix(s, 2, 6, 10, 14, msg[4], msg[5]);
      s = g_mix(s, 3, 7, 11, 15, msg[6], msg[7]);
      s = g_mix(s, 0, 5, 10, 15, msg[8], msg[9]);
      s = g_mix(s, 1, 6, 11, 12, msg[10], msg[11]);
      s = g_mix(s, 2, 7, 8, 13, msg[12], msg[13]);
      s = g_mix(s, 3, 4, 9, 14, msg[14], msg[15]);
      for (int i = 0; i < 16; i++) perm[i] = msg[blk3_pkg::PERM[i]];
      msg = perm;
    end
    for (int i = 0; i < 8; i++) res[i] = s[i] ^ s[i + 8];
    return res;
  endfunction

  // key words when keyed, IV otherwise; read live
  function automatic cv_t base_cv();
    cv_t w;
    for (int i = 0; i < 8; i++)
      w[i] = keyed_mode ? key_reg[i >> 1][32 * (i & 1) +: 32] : blk3_pkg::IV[i];
    return w;
  endfunction

  function automatic blk3_pkg::word_t mode_flag();
    return keyed_mode ? 32'(blk3_pkg::FL_KEYED) : 32'd0;
  endfunction

  function automatic blk3_pkg::word_t chunk_flags();
    return mode_flag() | ((blocks_done == 0) ? 32'(blk3_pkg::FL_CHUNK_START) : 32'd0);
  endfunction

  function automatic cv_t start_cv();
    return (blocks_done == 0) ? base_cv() : chain_cv;
  endfunction

  // bytes past the fill point read as zero
  function automatic blk_t buffer_words();
    blk_t m;
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 4; j++)
        m[i][8 * j +: 8] = (4 * i + j < fill) ? blk_buf[4 * i + j] : 8'd0;
    return m;
  endfunction

  task automatic restart_message();
    chain_cv    = base_cv();
    fill        = 0;
    blocks_done = 0;
    chunk_ctr   = '0;
    stack_depth = 0;
  endtask

  task automatic absorb_byte(logic [7:0] b);
    cv_t         nv;
    logic [63:0] total;
    if (fill >= blk3_pkg::BLOCK_BYTES) begin
      if (blocks_done >= blk3_pkg::LAST_BLOCK) begin
        nv = compress(start_cv(), buffer_words(), chunk_ctr, 64,
                      chunk_flags() | 32'(blk3_pkg::FL_CHUNK_END));
        total = chunk_ctr + 64'd1;
        // trailing-zero merge rule
        while (total[0] == 1'b0 && stack_depth > 0) begin
          stack_depth--;
          nv = compress(base_cv(), {nv, val_stack[stack_depth]}, '0, 64,
                        mode_flag() | 32'(blk3_pkg::FL_PARENT));
          total = total >> 1;
        end
        if (stack_depth >= STACK_ENTRIES) stack_depth = STACK_ENTRIES - 1;
        val_stack[stack_depth] = nv;
        stack_depth++;
        chunk_ctr++;
        blocks_done = 0;
        chain_cv = base_cv();
      end else begin
        chain_cv = compress(start_cv(), buffer_words(), chunk_ctr, 64, chunk_flags());
        blocks_done++;
      end
      fill = 0;
    end
    blk_buf[fill & 63] = b;
    fill++;
  endtask

  task automatic predict_digest();
    cv_t             cv;
    cv_t             nv;
    blk_t            m;
    logic [63:0]     ctr;
    blk3_pkg::word_t len;
    blk3_pkg::word_t flags;
    int unsigned     i;
    cv    = start_cv();
    m     = buffer_words();
    ctr   = chunk_ctr;
    len   = fill;
    flags = chunk_flags() | 32'(blk3_pkg::FL_CHUNK_END);
    i     = stack_depth;
    while (i > 0) begin
      i--;
      nv    = compress(cv, m, ctr, len, flags);
      cv    = base_cv();
      m     = {nv, val_stack[i]};
      ctr   = '0;
      len   = 64;
      flags = mode_flag() | 32'(blk3_pkg::FL_PARENT);
    end
    nv = compress(cv, m, '0, len, flags | 32'(blk3_pkg::FL_ROOT));
    for (int k = 0; k < 8; k++)
      digest_q.push_back('{word: nv[k], idx: 3'(k), last: (k == 7)});
    restart_message();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t exp;
    if (!rst_ni) begin
      keyed_mode = 1'b0;
      for (int k = 0; k < 4; k++) key_reg[k] = '0;
      digest_q.delete();
      err_count_o = 0;
      restart_message();
    end else begin
      if (cfg_we_i) begin
        case (blk3_pkg::cfg_idx_e'(cfg_idx_i))
          blk3_pkg::CFG_KEYED_MODE: keyed_mode = cfg_wdata_i[0];
          blk3_pkg::CFG_KEY_0_7:    key_reg[0] = cfg_wdata_i;
          blk3_pkg::CFG_KEY_8_15:   key_reg[1] = cfg_wdata_i;
          blk3_pkg::CFG_KEY_16_23:  key_reg[2] = cfg_wdata_i;
          blk3_pkg::CFG_KEY_24_31:  key_reg[3] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (byte_valid_i) absorb_byte(data_byte_i);
        if (end_of_message_i) predict_digest();
      end
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d", $time, digest_word_i,
                   word_index_i);
          err_count_o++;
        end else begin
          exp = digest_q.pop_front();
          if (digest_word_i !== exp.word) begin
            $display("%0t: digest_word exp %h got %h", $time, exp.word, digest_word_i);
            err_count_o++;
          end
          if (word_index_i !== exp.idx) begin
            $display("%0t: word_index exp %0d got %0d", $time, exp.idx, word_index_i);
            err_count_o++;
          end
          if (last_word_i !== exp.last) begin
            $display("%0t: last_word exp %0b got %0b", $time, exp.last, last_word_i);
            err_count_o++;
          end
        end
      end
    end
    pending_o = digest_q.size();
  end

endmodule

// File: tb/blake3_stream_hasher_top_tb.sv
// Testbench top: stimulus, config phases, watchdog and verdict for the BLAKE3 hasher.
module blake3_stream_hasher_top_tb;

  localparam int unsigned IDLE_LIMIT   = 20000;  // cycles without any transfer
  localparam int unsigned RAND_ITEMS   = 200;
  localparam int unsigned NUM_SETTINGS = 5;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [63:0] cfg_wdata;
  logic        calm;      // no gaps on either side while set
  int          err_count;
  int          pending;
  int unsigned items_sent;
  int unsigned msgs_sent;
  int unsigned words_seen;
  int unsigned idle_cycles;

  blk3_in_if  in_if ();
  blk3_out_if out_if ();

  blake3_stream_hasher_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  blk3_digest_checker chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_if.valid),
    .in_ready_i       (in_if.ready),
    .data_byte_i      (in_if.data_byte),
    .byte_valid_i     (in_if.byte_valid),
    .end_of_message_i (in_if.end_of_message),
    .out_valid_i      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .digest_word_i    (out_if.digest_word),
    .word_index_i     (out_if.word_index),
    .last_word_i      (out_if.last_word),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .err_count_o      (err_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly no gap, some short gaps, a few long ones; none while calm.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sink side: random stall runs on the digest channel.
  initial begin
    int unsigned n;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = gap_len();
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      idle_cycles <= 0;
      words_seen  <= 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_if.valid && out_if.ready) words_seen <= words_seen + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d digest words outstanding", $time, pending);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(logic [7:0] data, logic bv, logic eom);
    int unsigned n;
    n = gap_len();
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= data;
    in_if.byte_valid     <= bv;
    in_if.end_of_message <= eom;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    if (bv || eom) items_sent++;
  endtask

  // One message; the end marker rides on the last byte or follows it alone.
  task automatic send_message(int unsigned len, bit eom_on_last);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);  // ignored
      send_item(8'($urandom), 1'b1, eom_on_last && (k == len - 1));
    end
    if (len == 0 || !eom_on_last) send_item(8'($urandom), 1'b0, 1'b1);
    msgs_sent++;
  endtask

  // Wait for all digest words, then let the block settle before config writes.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(blk3_pkg::cfg_idx_e idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] k3);
    cfg_write(blk3_pkg::CFG_KEY_0_7, k0);
    cfg_write(blk3_pkg::CFG_KEY_8_15, k1);
    cfg_write(blk3_pkg::CFG_KEY_16_23, k2);
    cfg_write(blk3_pkg::CFG_KEY_24_31, k3);
  endtask

  initial begin
    int unsigned setting;
    int unsigned len;
    int unsigned r;
    int unsigned target;
    in_if.valid          = 1'b0;
    in_if.data_byte      = '0;
    in_if.byte_valid     = 1'b0;
    in_if.end_of_message = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    calm                 = 1'b0;
    items_sent           = 0;
    msgs_sent            = 0;
    rst_n                = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, plain mode from reset: empty message, single extreme bytes with
    // the end marker on the byte, a bare item in the middle that does nothing,
    // and an end marker arriving alone after a few bytes.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    drain();

    // Random phases across mode/key settings, extremes included.
    for (setting = 0; setting < NUM_SETTINGS; setting++) begin
      case (setting)
        0: ;  // plain, registers at reset values
        1: cfg_write(blk3_pkg::CFG_KEYED_MODE, 64'd1);  // keyed with all-zero key
        2: load_key('1, '1, '1, '1);
        3: load_key({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        default: begin
          // back to plain with other bits of the mode word set; indexes past
          // the register map must be ignored
          cfg_write(blk3_pkg::CFG_KEYED_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
          cfg_write(blk3_pkg::cfg_idx_e'(3'd5), {$urandom, $urandom});
          cfg_write(blk3_pkg::cfg_idx_e'(3'd6), '1);
          cfg_write(blk3_pkg::cfg_idx_e'(3'd7), {$urandom, $urandom});
        end
      endcase
      cfg_we <= 1'b0;
      @(negedge clk);
      calm   = (setting == 2);
      target = items_sent + RAND_ITEMS / NUM_SETTINGS;
      r      = 0;
      while (items_sent < target) begin
        // block edges: one byte past a full block, and an exactly full block
        if (r == 0 && setting == 0)      len = 65;
        else if (r == 0 && setting == 2) len = 64;
        else                             len = $urandom_range(0, 30);
        send_message(len, $urandom_range(0, 1));
        r++;
      end
      calm = 1'b0;
      drain();
    end

    drain();
    $display("covered %0d messages, %0d counted input transfers, %0d digest words",
             msgs_sent, items_sent, words_seen);
    $display("plain and keyed modes, zero/ones/random keys, full and partial block ends");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
